[design/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define PS2_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also holds through reset
`define PS2_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[design/ps2mpd_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mpd_pkg
// Types and constants shared by the PS/2 mouse packet decoder modules.
// ----------------------------------------------------------------------------
package ps2mpd_pkg;

  localparam int POSITION_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF    = 32;

  localparam int LIMIT_BITS     = 12;
  localparam int WHEEL_BITS     = 32;
  localparam int BUTTON_BITS    = 6;
  localparam int MODE_BITS      = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  localparam logic [LIMIT_BITS-1:0] LIMIT_X_RST = 12'd639;
  localparam logic [LIMIT_BITS-1:0] LIMIT_Y_RST = 12'd479;
  localparam int CURSOR_X_RST = 319;
  localparam int CURSOR_Y_RST = 239;

  // wheel protocol codes, code 3 decodes like the 8-bit wheel
  localparam logic [MODE_BITS-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_WHEEL = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FIVE  = 2'd2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE,
    REG_WHEEL_MODE,
    REG_LIMIT_X,
    REG_LIMIT_Y
  } cfg_reg_t;

  // complete packet handed from the framer to the tracker
  typedef struct packed {
    logic                 done;
    logic [MODE_BITS-1:0] mode;
    logic [7:0]           b0;
    logic [7:0]           b1;
    logic [7:0]           b2;
    logic [7:0]           b3;
  } packet_t;

endpackage

[design/ps2_mouse_packet_decoder.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// PS/2 mouse packet decoder with plain, wheel and five-button protocols.
// ----------------------------------------------------------------------------
// Usage:
//   Raw mouse bytes enter on data_byte with in_valid/in_ready; one result per
//   complete packet leaves on out_valid/out_ready. Bytes that do not finish a
//   packet, bytes taken while disabled and out-of-sync first bytes give none.
//   Registers (enable, wheel_mode, limit_x, limit_y) are written through
//   cfg_we/cfg_index/cfg_data; the user must write them only while no
//   transfer is pending, which the block itself does not enforce.
//   Throughput: one byte per cycle while in_ready is high. A byte passes the
//   input register, then the tracker state and out_valid are registered; the
//   tracker state itself is the result register, held while out_valid waits.
//   Reset: all totals clear, pointer returns to its home position, the
//   decoder is disabled in plain mode and nothing is in flight.
//   Stall: while a result waits, bytes keep flowing in until a byte that
//   completes the next packet reaches the tracker; it then waits in the input
//   register and in_ready drops until the waiting result is taken.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder #(
  parameter int POSITION_BITS = ps2mpd_pkg::POSITION_BITS_DEF,
  parameter int COUNT_BITS    = ps2mpd_pkg::COUNT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [ps2mpd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [ps2mpd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [7:0]                               data_byte,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [POSITION_BITS-1:0]                 pos_x,
  output logic [POSITION_BITS-1:0]                 pos_y,
  output logic [ps2mpd_pkg::BUTTON_BITS-1:0]       button_state,
  output logic signed [ps2mpd_pkg::WHEEL_BITS-1:0] scroll_total,
  output logic [COUNT_BITS-1:0]                    left_presses,
  output logic [COUNT_BITS-1:0]                    right_presses,
  output logic [COUNT_BITS-1:0]                    middle_presses,
  output logic [COUNT_BITS-1:0]                    move_count,
  output logic                                     overflow_dropped
);
  import ps2mpd_pkg::*;

  logic                  enable;
  logic [MODE_BITS-1:0]  wheel_mode;
  logic [LIMIT_BITS-1:0] limit_x;
  logic [LIMIT_BITS-1:0] limit_y;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       advance;
  logic       fire;
  packet_t    pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      wheel_mode <= MODE_PLAIN;
      limit_x    <= LIMIT_X_RST;
      limit_y    <= LIMIT_Y_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:     enable     <= cfg_data[0];
        REG_WHEEL_MODE: wheel_mode <= cfg_data[MODE_BITS-1:0];
        REG_LIMIT_X:    limit_x    <= cfg_data[LIMIT_BITS-1:0];
        REG_LIMIT_Y:    limit_y    <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a byte moves on unless it completes a packet while a result still waits
  assign advance  = byte_valid && (!pkt.done || !out_valid || out_ready);
  assign fire     = advance && pkt.done;
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_q <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  ps2mpd_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_q     (byte_q),
    .advance    (advance),
    .enable     (enable),
    .wheel_mode (wheel_mode),
    .pkt        (pkt)
  );

  ps2mpd_tracker #(
    .POSITION_BITS (POSITION_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_tracker (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .pkt              (pkt),
    .limit_x          (limit_x),
    .limit_y          (limit_y),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .button_state     (button_state),
    .scroll_total     (scroll_total),
    .left_presses     (left_presses),
    .right_presses    (right_presses),
    .middle_presses   (middle_presses),
    .move_count       (move_count),
    .overflow_dropped (overflow_dropped)
  );

endmodule

[design/ps2mpd_framer.sv]
// ----------------------------------------------------------------------------
// ps2mpd_framer
// Gathers raw bytes into 3- or 4-byte packets and resynchronizes on byte 0.
// ----------------------------------------------------------------------------
module ps2mpd_framer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  input  logic [7:0]                      byte_q,
  input  logic                            advance,
  input  logic                            enable,
  input  logic [ps2mpd_pkg::MODE_BITS-1:0] wheel_mode,
  output ps2mpd_pkg::packet_t             pkt
);
  import ps2mpd_pkg::*;

  logic [1:0] pos;
  logic [7:0] held [3];
  logic       sync_drop;
  logic       complete;
  logic       take;

  assign sync_drop = (pos == 2'd0) && !byte_q[3];
  // a mode change mid-packet completes at the first byte at or past the end
  assign complete  = (wheel_mode == MODE_PLAIN) ? (pos >= 2'd2) : (pos == 2'd3);
  assign take      = advance && enable && !sync_drop;

  always_comb begin
    pkt.done = byte_valid && enable && !sync_drop && complete;
    pkt.mode = wheel_mode;
    pkt.b0   = held[0];
    pkt.b1   = held[1];
    pkt.b2   = (pos == 2'd2) ? byte_q : held[2];
    pkt.b3   = (pos == 2'd3) ? byte_q : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
    end else if (take) begin
      pos <= complete ? 2'd0 : pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !complete) begin
      case (pos)
        2'd0:    held[0] <= byte_q;
        2'd1:    held[1] <= byte_q;
        2'd2:    held[2] <= byte_q;
        default: ;
      endcase
    end
  end

endmodule

[design/ps2mpd_tracker.sv]
// ----------------------------------------------------------------------------
// ps2mpd_tracker
// Applies one packet: buttons, press counts, wheel total and clamped pointer.
// ----------------------------------------------------------------------------
module ps2mpd_tracker #(
  parameter int POSITION_BITS = ps2mpd_pkg::POSITION_BITS_DEF,
  parameter int COUNT_BITS    = ps2mpd_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  fire,
  input  ps2mpd_pkg::packet_t                   pkt,
  input  logic [ps2mpd_pkg::LIMIT_BITS-1:0]     limit_x,
  input  logic [ps2mpd_pkg::LIMIT_BITS-1:0]     limit_y,
  output logic [POSITION_BITS-1:0]              pos_x,
  output logic [POSITION_BITS-1:0]              pos_y,
  output logic [ps2mpd_pkg::BUTTON_BITS-1:0]    button_state,
  output logic signed [ps2mpd_pkg::WHEEL_BITS-1:0] scroll_total,
  output logic [COUNT_BITS-1:0]                 left_presses,
  output logic [COUNT_BITS-1:0]                 right_presses,
  output logic [COUNT_BITS-1:0]                 middle_presses,
  output logic [COUNT_BITS-1:0]                 move_count,
  output logic                                  overflow_dropped
);
  import ps2mpd_pkg::*;

  localparam int WIDE = ((POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS) + 2;
  localparam int POS_MAX_INT = (1 << POSITION_BITS) - 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] X_RST =
    (CURSOR_X_RST > POS_MAX_INT) ? POS_MAX : POSITION_BITS'(CURSOR_X_RST);
  localparam logic [POSITION_BITS-1:0] Y_RST =
    (CURSOR_Y_RST > POS_MAX_INT) ? POS_MAX : POSITION_BITS'(CURSOR_Y_RST);

  logic [POSITION_BITS-1:0]    cursor_x, cursor_y;
  logic [POSITION_BITS-1:0]    cursor_x_next, cursor_y_next;
  logic [BUTTON_BITS-1:0]      buttons, buttons_next;
  logic signed [WHEEL_BITS-1:0] wheel_sum, wheel_sum_next;
  logic [COUNT_BITS-1:0]       press_cnt [3];
  logic [COUNT_BITS-1:0]       moves;
  logic                        dropped;
  logic                        dropped_next;
  logic [2:0]                  rising;
  logic                        is_plain, is_five;
  logic signed [7:0]           wheel_z;
  logic signed [8:0]           dx, dy;
  logic signed [WIDE-1:0]      sum_x, sum_y, top_x, top_y, lim_x_w, lim_y_w, max_w;

  assign is_plain = (pkt.mode == MODE_PLAIN);
  assign is_five  = (pkt.mode == MODE_FIVE);

  always_comb begin
    buttons_next = {(is_five ? pkt.b3[5:4] : 2'b00), 1'b0, pkt.b0[2:0]};
    rising       = buttons_next[2:0] & ~buttons[2:0];

    wheel_z = is_five ? {{4{pkt.b3[3]}}, pkt.b3[3:0]} : signed'(pkt.b3);
    wheel_sum_next = is_plain ? wheel_sum : wheel_sum - WHEEL_BITS'(wheel_z);

    dropped_next = |pkt.b0[7:6];
    dx = signed'({pkt.b0[4], pkt.b1});
    dy = signed'({pkt.b0[5], pkt.b2});

    // effective limits never exceed the largest pointer value
    max_w   = WIDE'(POS_MAX);
    lim_x_w = WIDE'(limit_x);
    lim_y_w = WIDE'(limit_y);
    top_x   = (lim_x_w > max_w) ? max_w : lim_x_w;
    top_y   = (lim_y_w > max_w) ? max_w : lim_y_w;

    sum_x = signed'(WIDE'(cursor_x)) + WIDE'(dx);
    sum_y = signed'(WIDE'(cursor_y)) - WIDE'(dy);

    if (sum_x[WIDE-1])     cursor_x_next = '0;
    else if (sum_x > top_x) cursor_x_next = top_x[POSITION_BITS-1:0];
    else                    cursor_x_next = sum_x[POSITION_BITS-1:0];

    if (sum_y[WIDE-1])     cursor_y_next = '0;
    else if (sum_y > top_y) cursor_y_next = top_y[POSITION_BITS-1:0];
    else                    cursor_y_next = sum_y[POSITION_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x  <= X_RST;
      cursor_y  <= Y_RST;
      buttons   <= '0;
      wheel_sum <= '0;
      moves     <= '0;
      for (int i = 0; i < 3; i++) begin
        press_cnt[i] <= '0;
      end
    end else if (fire) begin
      buttons   <= buttons_next;
      wheel_sum <= wheel_sum_next;
      for (int i = 0; i < 3; i++) begin
        if (rising[i]) press_cnt[i] <= press_cnt[i] + COUNT_BITS'(1);
      end
      // overflowed packets leave the pointer alone
      if (!dropped_next) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
        moves    <= moves + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) dropped <= dropped_next;
  end

  assign pos_x            = cursor_x;
  assign pos_y            = cursor_y;
  assign button_state     = buttons;
  assign scroll_total     = wheel_sum;
  assign left_presses     = press_cnt[0];
  assign right_presses    = press_cnt[1];
  assign middle_presses   = press_cnt[2];
  assign move_count       = moves;
  assign overflow_dropped = dropped;

endmodule

[design/ps2mpd_checker.sv]
// ----------------------------------------------------------------------------
// ps2mpd_checker
// Port-level checks on the packet decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2mpd_checker #(
  parameter int POSITION_BITS = ps2mpd_pkg::POSITION_BITS_DEF,
  parameter int COUNT_BITS    = ps2mpd_pkg::COUNT_BITS_DEF
) (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     in_valid,
  input logic                                     in_ready,
  input logic                                     out_valid,
  input logic                                     out_ready,
  input logic [POSITION_BITS-1:0]                 pos_x,
  input logic [POSITION_BITS-1:0]                 pos_y,
  input logic [ps2mpd_pkg::BUTTON_BITS-1:0]       button_state,
  input logic signed [ps2mpd_pkg::WHEEL_BITS-1:0] scroll_total,
  input logic [COUNT_BITS-1:0]                    left_presses,
  input logic [COUNT_BITS-1:0]                    right_presses,
  input logic [COUNT_BITS-1:0]                    middle_presses,
  input logic [COUNT_BITS-1:0]                    move_count,
  input logic                                     overflow_dropped
);
  import ps2mpd_pkg::*;

  localparam int PAYLOAD_BITS =
    2 * POSITION_BITS + BUTTON_BITS + WHEEL_BITS + 4 * COUNT_BITS + 1;

  logic [PAYLOAD_BITS-1:0] payload;

  assign payload = {pos_x, pos_y, button_state, scroll_total, left_presses,
                    right_presses, middle_presses, move_count, overflow_dropped};

  // a waiting result stays offered
  `PS2_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)

  // a waiting result keeps its payload
  `PS2_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(payload))

  // reset empties both stages
  `PS2_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && in_ready)

  // input only backs up behind a stalled result
  `PS2_ASSERT(a_ready_cause, clk, rst, !in_ready |-> out_valid && !out_ready)

  // a new result comes from a byte that was transferred into the input register
  `PS2_ASSERT(a_result_source, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready, 2))

endmodule

bind ps2_mouse_packet_decoder ps2mpd_checker #(
  .POSITION_BITS (POSITION_BITS),
  .COUNT_BITS    (COUNT_BITS)
) u_ps2mpd_checker (.*);
